// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define RODF_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define RODF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/rodf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rodf_pkg
// Types, constants and the rank selection function of the distance filter.
// ----------------------------------------------------------------------------
package rodf_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int VALUE_W    = 12;
    localparam int RAW_W      = 16;
    localparam int MISS_W     = 8;
    localparam int RANK_W     = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MISS_LIMIT    = 2'd2;

    localparam logic [1:0] MODE_MIN    = 2'd0;
    localparam logic [1:0] MODE_MEDIAN = 2'd1;
    localparam logic [1:0] MODE_P10    = 2'd2;

    localparam logic [RAW_W-1:0]  MAX_GOOD_MM    = 16'd4000;
    localparam logic [1:0]        RESET_MODE     = MODE_MIN;
    localparam logic [4:0]        RESET_LENGTH   = 5'd16;
    localparam logic [MISS_W-1:0] RESET_LIMIT    = 8'd3;
    localparam logic [MISS_W-1:0] MISS_SATURATED = 8'd255;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVICT,
        ST_INSERT,
        ST_PICK,
        ST_OUT
    } rodf_state_t;

    // Command broadcast to every cell of the sorted chain.
    typedef struct packed {
        logic evict;
        logic insert;
    } rodf_op_t;

    // Sorted position to report for a window holding n values (n >= 1).
    // ceil(n/10) is (n + 9) / 10, done as a multiply by 205 and a shift by 11,
    // exact for the small counts that occur here.
    function automatic logic [RANK_W-1:0] pick_index(input logic [1:0] mode,
                                                     input logic [RANK_W-1:0] n);
        logic [17:0]       prod;
        logic [RANK_W-1:0] tenth;
        logic [RANK_W-1:0] pick;
        prod  = (18'(n) + 18'd9) * 18'd205;
        tenth = RANK_W'(prod >> 11);
        case (mode)
            MODE_MEDIAN: pick = n >> 1;
            MODE_P10:    pick = (tenth >= n) ? (n - RANK_W'(1)) : tenth;
            default:     pick = '0;
        endcase
        return pick;
    endfunction

endpackage

// File: sv/rank_order_distance_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rank_order_distance_filter
// Sliding-window order-statistic filter for one range-sensor channel.
// ----------------------------------------------------------------------------
// Each input transfer carries one reading and produces exactly one output
// transfer showing the filter state after it. A reading that does not enter
// the window (absent, faulty, zero or above 4000 mm) goes from its transfer
// straight to the output state; a good reading first passes the cell chain,
// which drops the oldest value once the window is full, shifts the new value
// into sorted place and then reads the selected rank. The block takes one
// reading at a time and accepts the next as soon as the previous result is in
// the output register, even if that result has not been taken yet. The window
// is held as a row of identical cells sorted in ascending order, each tagged
// with the ring slot its value came from, so the minimum, median or tenth
// percentile is a plain read of one cell. A write to a defined configuration
// register empties the window but keeps the filtered output, the raw distance
// and the miss counter; writes are expected only while no reading is in
// flight.
// ----------------------------------------------------------------------------
module rank_order_distance_filter #(
    parameter  int WINDOW_DEPTH = 16,
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1),
    localparam int OUT_W        = ((rodf_pkg::VALUE_W + rodf_pkg::RAW_W + CNT_W + 7) / 8) * 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rodf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rodf_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Reading stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rodf_pkg::RAW_W-1:0]        s_tdata,   // [15:0] distance
    input  logic [1:0]                        s_tuser,   // [0] has_reading, [1] sensor_ok
    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [11:0] filtered_distance, [27:12] raw_distance,
    // [27+CNT_W:28] valid_count, zero fill above
    output logic [OUT_W-1:0]                  m_tdata,
    output logic                              m_tuser    // [0] reading_accepted
);
    import rodf_pkg::*;

    localparam int TAG_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

    rodf_state_t         state_reg;
    rodf_state_t         state_next;

    logic [1:0]          mode_reg;
    logic [4:0]          wlen_reg;
    logic [MISS_W-1:0]   limit_reg;

    logic [CNT_W-1:0]    fill_reg;
    logic [TAG_W-1:0]    wr_reg;
    logic [MISS_W-1:0]   miss_reg;
    logic [VALUE_W-1:0]  filt_reg;
    logic [RAW_W-1:0]    raw_reg;
    logic [VALUE_W-1:0]  x_reg;
    logic                acc_reg;

    logic                m_valid_reg;
    logic [OUT_W-1:0]    m_data_reg;
    logic                m_user_reg;

    logic                in_fire;
    logic                has_reading;
    logic                sensor_ok;
    logic                good;
    logic                bad;
    logic [CNT_W-1:0]    len_eff;
    logic                full;
    logic [MISS_W-1:0]   miss_inc;
    logic                out_free;
    logic                out_load;
    logic                cfg_hit;
    logic [TAG_W-1:0]    wr_inc;
    logic [RANK_W-1:0]   rank;
    logic [VALUE_W-1:0]  pick_value;
    rodf_op_t            chain_op;

    assign has_reading = s_tuser[0];
    assign sensor_ok   = s_tuser[1];
    assign good        = has_reading && sensor_ok && (s_tdata != '0)
                         && (s_tdata <= MAX_GOOD_MM);
    assign bad         = has_reading && !good;

    // Window length as used: zero acts as one, anything past the chain as full depth.
    always_comb
    begin
        if (wlen_reg == '0)
            len_eff = CNT_W'(1);
        else if (32'(wlen_reg) > 32'(WINDOW_DEPTH))
            len_eff = CNT_W'(WINDOW_DEPTH);
        else
            len_eff = CNT_W'(wlen_reg);
    end

    assign full     = (fill_reg == len_eff);
    assign miss_inc = (miss_reg == MISS_SATURATED) ? miss_reg : miss_reg + MISS_W'(1);
    assign out_free = !m_valid_reg || m_tready;
    assign wr_inc   = ((CNT_W'(wr_reg) + CNT_W'(1)) == len_eff) ? '0 : wr_reg + TAG_W'(1);
    assign rank     = pick_index(mode_reg, RANK_W'(fill_reg));

    always_comb
    begin
        cfg_hit = 1'b0;
        unique case (cfg_index)
            CFG_FILTER_MODE:   cfg_hit = 1'b1;
            CFG_WINDOW_LENGTH: cfg_hit = 1'b1;
            CFG_MISS_LIMIT:    cfg_hit = 1'b1;
            default:           cfg_hit = 1'b0;
        endcase
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (s_tvalid)
                begin
                    if (good)
                        state_next = full ? ST_EVICT : ST_INSERT;
                    else
                        state_next = ST_OUT;
                end
            ST_EVICT:  state_next = ST_INSERT;
            ST_INSERT: state_next = ST_PICK;
            ST_PICK:   state_next = ST_OUT;
            ST_OUT:
                if (out_free)
                    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // State-decoded controls.
    always_comb
    begin
        s_tready        = 1'b0;
        chain_op.evict  = 1'b0;
        chain_op.insert = 1'b0;
        out_load        = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_tready        = 1'b1;
            ST_EVICT:  chain_op.evict  = 1'b1;
            ST_INSERT: chain_op.insert = 1'b1;
            ST_PICK:   ;
            ST_OUT:    out_load        = out_free;
            default:   ;
        endcase
    end

    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            mode_reg    <= RESET_MODE;
            wlen_reg    <= RESET_LENGTH;
            limit_reg   <= RESET_LIMIT;
            fill_reg    <= '0;
            wr_reg      <= '0;
            miss_reg    <= '0;
            filt_reg    <= '0;
            raw_reg     <= '0;
            acc_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (in_fire)
            begin
                acc_reg <= good;
                if (has_reading)
                    raw_reg <= s_tdata;
                if (good)
                    miss_reg <= '0;
                else if (bad)
                begin
                    miss_reg <= miss_inc;
                    if (miss_inc >= limit_reg)
                    begin
                        filt_reg <= '0;
                        fill_reg <= '0;
                        wr_reg   <= '0;
                    end
                end
            end

            if (chain_op.evict)
                fill_reg <= fill_reg - CNT_W'(1);

            if (chain_op.insert)
            begin
                fill_reg <= fill_reg + CNT_W'(1);
                wr_reg   <= wr_inc;
            end

            if (state_reg == ST_PICK)
                filt_reg <= pick_value;

            if (out_load)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;

            // Any write to a defined register empties the window.
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_FILTER_MODE:   mode_reg  <= cfg_data[1:0];
                    CFG_WINDOW_LENGTH: wlen_reg  <= cfg_data[4:0];
                    CFG_MISS_LIMIT:    limit_reg <= cfg_data;
                    default:           ;
                endcase
                if (cfg_hit)
                begin
                    fill_reg <= '0;
                    wr_reg   <= '0;
                end
            end
        end
    end

    // Payload registers: the value taken with an accepted reading, and the result.
    always_ff @(posedge clk)
    begin
        if (in_fire)
            x_reg <= s_tdata[VALUE_W-1:0];
        if (out_load)
        begin
            m_data_reg <= OUT_W'({fill_reg, raw_reg, filt_reg});
            m_user_reg <= acc_reg;
        end
    end

    rodf_chain #(
        .DEPTH (WINDOW_DEPTH),
        .TAG_W (TAG_W),
        .CNT_W (CNT_W)
    ) u_chain (
        .clk        (clk),
        .op         (chain_op),
        .count      (fill_reg),
        .new_value  (x_reg),
        .slot       (wr_reg),
        .pick       (rank[TAG_W-1:0]),
        .pick_value (pick_value)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// File: sv/rodf_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rodf_cell
// One position of the sorted window chain: a value and the ring slot it came
// from, shifting left on eviction and right on insertion.
// ----------------------------------------------------------------------------
module rodf_cell #(
    parameter int TAG_W = 4
) (
    input  logic                               clk,
    input  rodf_pkg::rodf_op_t                 op,
    input  logic                               occupied,
    input  logic                               at_end,
    input  logic [rodf_pkg::VALUE_W-1:0]       new_value,
    input  logic [TAG_W-1:0]                   new_tag,
    input  logic [TAG_W-1:0]                   evict_tag,
    input  logic [rodf_pkg::VALUE_W-1:0]       left_value,
    input  logic [TAG_W-1:0]                   left_tag,
    input  logic                               left_gt,
    input  logic [rodf_pkg::VALUE_W-1:0]       right_value,
    input  logic [TAG_W-1:0]                   right_tag,
    input  logic                               ev_in,
    output logic [rodf_pkg::VALUE_W-1:0]       value,
    output logic [TAG_W-1:0]                   tag,
    output logic                               gt_out,
    output logic                               ev_out
);
    import rodf_pkg::*;

    logic [VALUE_W-1:0] value_reg;
    logic [TAG_W-1:0]   tag_reg;

    // The evicted cell and everything to its right pull in the right neighbor.
    assign ev_out = ev_in | (occupied & (tag_reg == evict_tag));
    assign gt_out = occupied & (value_reg > new_value);
    assign value  = value_reg;
    assign tag    = tag_reg;

    always_ff @(posedge clk)
    begin
        if (op.evict && ev_out)
        begin
            value_reg <= right_value;
            tag_reg   <= right_tag;
        end
        else if (op.insert)
        begin
            if (left_gt)
            begin
                value_reg <= left_value;
                tag_reg   <= left_tag;
            end
            else if (gt_out || at_end)
            begin
                value_reg <= new_value;
                tag_reg   <= new_tag;
            end
        end
    end

endmodule

// File: sv/rodf_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rodf_chain
// Row of cells holding the window in ascending order, with a rank read port.
// ----------------------------------------------------------------------------
module rodf_chain #(
    parameter int DEPTH = 16,
    parameter int TAG_W = 4,
    parameter int CNT_W = 5
) (
    input  logic                          clk,
    input  rodf_pkg::rodf_op_t            op,
    input  logic [CNT_W-1:0]              count,
    input  logic [rodf_pkg::VALUE_W-1:0]  new_value,
    input  logic [TAG_W-1:0]              slot,
    input  logic [TAG_W-1:0]              pick,
    output logic [rodf_pkg::VALUE_W-1:0]  pick_value
);
    import rodf_pkg::*;

    logic [VALUE_W-1:0] cell_value [DEPTH];
    logic [TAG_W-1:0]   cell_tag   [DEPTH];
    logic               cell_gt    [DEPTH];
    logic               cell_ev    [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [VALUE_W-1:0] lv;
        logic [TAG_W-1:0]   lt;
        logic               lg;
        logic               le;
        logic [VALUE_W-1:0] rv;
        logic [TAG_W-1:0]   rt;

        if (i == 0)
        begin : g_first
            assign lv = '0;
            assign lt = '0;
            assign lg = 1'b0;
            assign le = 1'b0;
        end
        else
        begin : g_inner_left
            assign lv = cell_value[i-1];
            assign lt = cell_tag[i-1];
            assign lg = cell_gt[i-1];
            assign le = cell_ev[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign rv = '0;
            assign rt = '0;
        end
        else
        begin : g_inner_right
            assign rv = cell_value[i+1];
            assign rt = cell_tag[i+1];
        end

        rodf_cell #(
            .TAG_W (TAG_W)
        ) u_cell (
            .clk         (clk),
            .op          (op),
            .occupied    (CNT_W'(i) < count),
            .at_end      (CNT_W'(i) == count),
            .new_value   (new_value),
            .new_tag     (slot),
            .evict_tag   (slot),
            .left_value  (lv),
            .left_tag    (lt),
            .left_gt     (lg),
            .right_value (rv),
            .right_tag   (rt),
            .ev_in       (le),
            .value       (cell_value[i]),
            .tag         (cell_tag[i]),
            .gt_out      (cell_gt[i]),
            .ev_out      (cell_ev[i])
        );
    end

    assign pick_value = cell_value[pick];

endmodule

// File: sv/rodf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rodf_checker
// Port-level checks on the result stream of the distance filter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rodf_checker #(
    parameter  int WINDOW_DEPTH = 16,
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1),
    localparam int OUT_W        = ((rodf_pkg::VALUE_W + rodf_pkg::RAW_W + CNT_W + 7) / 8) * 8
) (
    input logic             clk,
    input logic             rst_n,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic             m_tuser
);
    import rodf_pkg::*;

    localparam int CNT_LSB = VALUE_W + RAW_W;

    `RODF_ASSERT_ALWAYS(a_idle_in_reset, clk, !rst_n |=> !m_tvalid, "result valid during reset")

    `RODF_ASSERT(a_result_held, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")

    `RODF_ASSERT(a_count_bound, clk, rst_n, m_tvalid |-> m_tdata[CNT_LSB +: CNT_W] <= CNT_W'(WINDOW_DEPTH), "window count beyond depth")

    `RODF_ASSERT(a_filtered_bound, clk, rst_n, m_tvalid |-> m_tdata[VALUE_W-1:0] <= MAX_GOOD_MM[VALUE_W-1:0], "filtered distance above range")

    `RODF_ASSERT(a_accept_nonempty, clk, rst_n, m_tvalid && m_tuser |-> m_tdata[CNT_LSB +: CNT_W] != '0 && m_tdata[VALUE_W-1:0] != '0, "accepted reading left window empty")

endmodule

bind rank_order_distance_filter rodf_checker #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_rodf_checker (.*);
